// File: rtl/core/assert_macros.svh
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, a, c)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

// File: rtl/core/fwc_pkg.sv
`default_nettype none
package fwc_pkg;

  // Geometry
  localparam int WAYS           = 4;
  localparam int SETS           = 16;
  localparam int WORDS_PER_LINE = 16;
  localparam int MEM_WORDS      = 65536;

  localparam int WAY_W  = $clog2(WAYS);
  localparam int SET_W  = $clog2(SETS);
  localparam int OFF_W  = $clog2(WORDS_PER_LINE);
  localparam int MEM_AW = $clog2(MEM_WORDS);
  localparam int ADDR_W = 18;
  localparam int WORD_W = ADDR_W - 2;
  localparam int TAG_W  = WORD_W - OFF_W - SET_W;
  localparam int LW_AW  = WAY_W + SET_W + OFF_W;
  localparam int CNT_W  = MEM_AW;

  // Request opcodes
  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_PRELOAD = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] address;
    logic [31:0]       wr_word;
  } req_t;

  typedef struct packed {
    logic [31:0]      rd_word;
    logic             hit;
    logic             wrote_back;
    logic [WAY_W-1:0] way_used;
  } rsp_t;

  // Datapath commands
  typedef enum logic [2:0] {
    DP_NOP,
    DP_CLEAR,
    DP_CAPTURE,
    DP_LOOKUP,
    DP_WB_RD,
    DP_FILL_RD,
    DP_ACCESS,
    DP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [CNT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic       hit;
    logic       victim_dirty;
    logic [1:0] opcode;
  } st_t;

endpackage
`default_nettype wire

// File: rtl/core/fwc_datapath.sv
`default_nettype none
module fwc_datapath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire fwc_pkg::cmd_t cmd,
  input  wire fwc_pkg::req_t in_data,
  output fwc_pkg::st_t       st,
  output fwc_pkg::rsp_t      out_data
);
  import fwc_pkg::*;

  req_t req_r;
  rsp_t out_r;

  // Field split of the held request
  logic [WORD_W-1:0] word;
  logic [OFF_W-1:0]  off;
  logic [SET_W-1:0]  set_i;
  logic [TAG_W-1:0]  tag;
  assign word  = req_r.address[ADDR_W-1:2];
  assign off   = word[OFF_W-1:0];
  assign set_i = word[OFF_W+SET_W-1:OFF_W];
  assign tag   = word[WORD_W-1:OFF_W+SET_W];

  // Line state
  logic [TAG_W-1:0] tag_r   [WAYS][SETS];
  logic [SETS-1:0]  valid_r [WAYS];
  logic [SETS-1:0]  dirty_r [WAYS];
  logic [SETS-1:0]  ref_r   [WAYS];
  logic [WAY_W-1:0] ptr_r   [SETS];

  logic [WAY_W-1:0] way_r;
  logic             hit_r;
  logic             wb_r;
  logic [TAG_W-1:0] old_tag_r;

  // Memories and their registered reads
  logic [31:0] lw_mem [2**LW_AW];
  logic [31:0] bm_mem [MEM_WORDS];
  logic [31:0] lw_q;
  logic [31:0] bm_q;
  logic             wpend_r;
  logic             fpend_r;
  logic [OFF_W-1:0] pend_idx_r;

  // Hit search, first invalid way, second-chance sweep
  logic             hit_c;
  logic [WAY_W-1:0] hit_way;
  logic             any_inv;
  logic [WAY_W-1:0] inv_way;
  logic             found;
  logic [WAY_W-1:0] vic;
  logic [WAY_W-1:0] sw;
  logic [WAYS-1:0]  clr;
  logic [WAY_W-1:0] way_sel;

  always_comb begin
    hit_c   = 1'b0;
    hit_way = '0;
    any_inv = 1'b0;
    inv_way = '0;
    found   = 1'b0;
    vic     = ptr_r[set_i];
    clr     = '0;
    sw      = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_c && valid_r[w][set_i] && tag_r[w][set_i] == tag) begin
        hit_c   = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!any_inv && !valid_r[w][set_i]) begin
        any_inv = 1'b1;
        inv_way = WAY_W'(w);
      end
    end
    for (int k = 0; k < WAYS; k++) begin
      sw = ptr_r[set_i] + WAY_W'(k);
      if (!found) begin
        if (ref_r[sw][set_i]) begin
          clr[sw] = 1'b1;
        end else begin
          found = 1'b1;
          vic   = sw;
        end
      end
    end
    way_sel = hit_c ? hit_way : (any_inv ? inv_way : vic);
  end

  assign st.hit          = hit_c;
  assign st.victim_dirty = !hit_c && !any_inv && dirty_r[vic][set_i];
  assign st.opcode       = req_r.opcode;

  logic cached;
  assign cached = (req_r.opcode == OP_READ) || (req_r.opcode == OP_WRITE);

  // Request capture and lookup results
  always_ff @(posedge clk) begin
    if (cmd.op == DP_CAPTURE) begin
      req_r <= in_data;
    end
    if (cmd.op == DP_LOOKUP) begin
      way_r     <= way_sel;
      hit_r     <= hit_c;
      wb_r      <= st.victim_dirty;
      old_tag_r <= tag_r[vic][set_i];
      if (cached && !hit_c) begin
        tag_r[way_sel][set_i] <= tag;
      end
    end
  end

  // Valid, dirty, reference bits and sweep pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < WAYS; w++) begin
        valid_r[w] <= '0;
        dirty_r[w] <= '0;
        ref_r[w]   <= '0;
      end
      for (int s = 0; s < SETS; s++) begin
        ptr_r[s] <= '0;
      end
    end else begin
      if (cmd.op == DP_LOOKUP && cached) begin
        if (hit_c) begin
          if (req_r.opcode == OP_READ) begin
            ref_r[hit_way][set_i] <= 1'b1;
          end
        end else begin
          if (!any_inv) begin
            for (int w = 0; w < WAYS; w++) begin
              if (clr[w]) begin
                ref_r[w][set_i] <= 1'b0;
              end
            end
            ptr_r[set_i] <= vic + WAY_W'(1);
          end
          valid_r[way_sel][set_i] <= 1'b1;
          dirty_r[way_sel][set_i] <= 1'b0;
        end
      end
      if (cmd.op == DP_ACCESS && req_r.opcode == OP_WRITE) begin
        dirty_r[way_r][set_i] <= 1'b1;
      end
    end
  end

  // Pending memory writes, issued in the cycle after each read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpend_r <= 1'b0;
      fpend_r <= 1'b0;
    end else begin
      wpend_r <= (cmd.op == DP_WB_RD);
      fpend_r <= (cmd.op == DP_FILL_RD);
    end
    pend_idx_r <= cmd.idx[OFF_W-1:0];
  end

  // Line word memory
  logic             lw_we;
  logic [LW_AW-1:0] lw_wa;
  logic [31:0]      lw_wd;
  always_comb begin
    lw_we = 1'b0;
    lw_wa = {way_r, set_i, pend_idx_r};
    lw_wd = bm_q;
    if (fpend_r) begin
      lw_we = 1'b1;
    end else if (cmd.op == DP_ACCESS && req_r.opcode == OP_WRITE) begin
      lw_we = 1'b1;
      lw_wa = {way_r, set_i, off};
      lw_wd = req_r.wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (lw_we) begin
      lw_mem[lw_wa] <= lw_wd;
    end
    if (cmd.op == DP_WB_RD) begin
      lw_q <= lw_mem[{way_r, set_i, cmd.idx[OFF_W-1:0]}];
    end else if (cmd.op == DP_ACCESS && req_r.opcode == OP_READ) begin
      lw_q <= lw_mem[{way_r, set_i, off}];
    end
  end

  // Backing memory
  logic              bm_we;
  logic [MEM_AW-1:0] bm_wa;
  logic [31:0]       bm_wd;
  always_comb begin
    bm_we = 1'b0;
    bm_wa = cmd.idx[MEM_AW-1:0];
    bm_wd = '0;
    if (cmd.op == DP_CLEAR) begin
      bm_we = 1'b1;
    end else if (wpend_r) begin
      bm_we = 1'b1;
      bm_wa = {old_tag_r, set_i, pend_idx_r};
      bm_wd = lw_q;
    end else if (cmd.op == DP_LOOKUP && req_r.opcode == OP_PRELOAD) begin
      bm_we = 1'b1;
      bm_wa = word[MEM_AW-1:0];
      bm_wd = req_r.wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm_mem[bm_wa] <= bm_wd;
    end
    if (cmd.op == DP_FILL_RD) begin
      bm_q <= bm_mem[{tag, set_i, cmd.idx[OFF_W-1:0]}];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD_OUT) begin
      if (cached) begin
        out_r.rd_word    <= (req_r.opcode == OP_READ) ? lw_q : '0;
        out_r.hit        <= hit_r;
        out_r.wrote_back <= wb_r;
        out_r.way_used   <= way_r;
      end else begin
        out_r <= '0;
      end
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

// File: rtl/core/fwc_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module fwc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire fwc_pkg::st_t  st,
  output fwc_pkg::cmd_t      cmd
);
  import fwc_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_WB,
    ST_WB_DRAIN,
    ST_FILL,
    ST_FILL_DRAIN,
    ST_ACCESS,
    ST_RESP
  } state_t;

  localparam logic [OFF_W-1:0] LINE_LAST = OFF_W'(WORDS_PER_LINE - 1);
  localparam logic [CNT_W-1:0] MEM_LAST  = CNT_W'(MEM_WORDS - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             can_load;

  assign can_load = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == MEM_LAST) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cnt_nxt = '0;
        if (st.opcode != OP_READ && st.opcode != OP_WRITE) state_nxt = ST_RESP;
        else if (st.hit) state_nxt = ST_ACCESS;
        else if (st.victim_dirty) state_nxt = ST_WB;
        else state_nxt = ST_FILL;
      end
      ST_WB: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r[OFF_W-1:0] == LINE_LAST) state_nxt = ST_WB_DRAIN;
      end
      ST_WB_DRAIN: begin
        cnt_nxt   = '0;
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r[OFF_W-1:0] == LINE_LAST) state_nxt = ST_FILL_DRAIN;
      end
      ST_FILL_DRAIN: state_nxt = ST_ACCESS;
      ST_ACCESS:     state_nxt = ST_RESP;
      ST_RESP: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath command decode
  always_comb begin
    cmd.op  = DP_NOP;
    cmd.idx = cnt_r;
    case (state_r)
      ST_CLEAR:  cmd.op = DP_CLEAR;
      ST_IDLE:   if (in_valid) cmd.op = DP_CAPTURE;
      ST_LOOKUP: cmd.op = DP_LOOKUP;
      ST_WB:     cmd.op = DP_WB_RD;
      ST_FILL:   cmd.op = DP_FILL_RD;
      ST_ACCESS: cmd.op = DP_ACCESS;
      ST_RESP:   if (can_load) cmd.op = DP_LOAD_OUT;
      default:   cmd.op = DP_NOP;
    endcase
  end

  `ASSERT_IMPLY(a_accept_ready, clk, rst_n, in_valid && !in_stall, state_r == ST_IDLE)
  `ASSERT_NEXT(a_hit_access, clk, rst_n, state_r == ST_LOOKUP && st.hit && (st.opcode == OP_READ || st.opcode == OP_WRITE), state_r == ST_ACCESS)
  `ASSERT_NEXT(a_fill_done, clk, rst_n, state_r == ST_FILL_DRAIN, state_r == ST_ACCESS)

endmodule
`default_nettype wire

// File: rtl/core/four_way_write_back_cache_core.sv
`default_nettype none
// Four-way, 16-set, 16-word-line write-back word cache with second-chance
// replacement over a 64K-word backing memory held inside the block. After
// reset the block clears the backing memory one word a cycle and holds
// in_stall high meanwhile. Requests are then handled one at a time by the
// controller: a preload or unused opcode goes from lookup to response, a
// hit adds an access step, a clean miss adds a 16-word line fill and drain
// before it, and a dirty miss adds a line write-back and drain before the
// fill; each line moves one word a cycle via the memory ports. A finished
// result waits in the output register while the next request is accepted.
module four_way_write_back_cache_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire fwc_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output fwc_pkg::rsp_t      out_data
);
  import fwc_pkg::*;

  cmd_t cmd;
  st_t  st;

  fwc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  fwc_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .st       (st),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
